// ===== rtl/mpq_pkg.sv =====
// shared types and codes for the max priority queue unit
// request and response structs, command and status codes, controller states
// no dependencies
package mpq_pkg;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;
    localparam logic [1:0] CMD_NOP  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int COUNT_W = 5;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] task_tag;
        logic [15:0] priority_req;
    } t_req;

    typedef struct packed {
        logic [31:0]        out_tag;
        logic [15:0]        out_priority;
        logic               out_valid;
        logic [1:0]         status;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
    } t_resp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_POS,
        S_SHIFT,
        S_RESP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       req_latch;
        logic       ptr_clr;
        logic       scan_en;
        logic       ptr_from_best;
        logic       shift_en;
        logic       push_wr;
        logic       count_inc;
        logic       count_dec;
        logic       res_load;
        logic       res_entry;
        logic [1:0] res_status;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic scan_done;
        logic shift_done;
    } t_dp_stat;

endpackage

// ===== rtl/mpq_dp.sv =====
// datapath of the max priority queue unit: entry memories, scan pointer,
// best-entry tracking, count register and response register
// depends on mpq_pkg
module mpq_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mpq_pkg::t_req    i_req,
    input  mpq_pkg::t_dp_cmd i_cmd,
    output mpq_pkg::t_dp_stat o_stat,
    output mpq_pkg::t_resp   o_resp
);
    import mpq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [31:0]   mem_tag  [QUEUE_DEPTH];
    logic [15:0]   mem_prio [QUEUE_DEPTH];

    logic [31:0]   r_req_tag;
    logic [15:0]   r_req_prio;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_ptr;
    logic [CW-1:0] r_rd_idx;
    logic          r_rd_live;
    logic [31:0]   r_rd_tag;
    logic [15:0]   r_rd_prio;
    logic [CW-1:0] r_best_idx;
    logic [31:0]   r_best_tag;
    logic [15:0]   r_best_prio;
    t_resp         r_resp;

    logic          issue_en;
    logic          issue_live;
    logic          best_upd;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_tag;
    logic [15:0]   wr_prio;
    logic [CW-1:0] idx_m1;
    logic [CW+COUNT_W-1:0] count_ext;

    assign issue_en   = i_cmd.scan_en | i_cmd.shift_en;
    assign issue_live = issue_en && (r_ptr < r_count);
    // first entry seeds the best, later ones replace it only when strictly greater
    assign best_upd   = i_cmd.scan_en && r_rd_live &&
                        ((r_rd_idx == '0) || (r_rd_prio > r_best_prio));
    assign idx_m1     = r_rd_idx - CW'(1);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[AW-1:0];
        wr_tag  = r_req_tag;
        wr_prio = r_req_prio;
        if (i_cmd.push_wr) begin
            wr_en = 1'b1;
        end else if (i_cmd.shift_en && r_rd_live) begin
            // move the entry just read one place down
            wr_en   = 1'b1;
            wr_addr = idx_m1[AW-1:0];
            wr_tag  = r_rd_tag;
            wr_prio = r_rd_prio;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.count_inc) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.count_dec) begin
            n_count = r_count - CW'(1);
        end
    end

    assign count_ext = {{COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_tag[wr_addr]  <= wr_tag;
            mem_prio[wr_addr] <= wr_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_tag  <= mem_tag[r_ptr[AW-1:0]];
        r_rd_prio <= mem_prio[r_ptr[AW-1:0]];
        r_rd_idx  <= r_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rd_live <= 1'b0;
            r_ptr     <= '0;
        end else begin
            r_count   <= n_count;
            r_rd_live <= issue_live;
            if (i_cmd.ptr_clr) begin
                r_ptr <= '0;
            end else if (i_cmd.ptr_from_best) begin
                r_ptr <= r_best_idx + CW'(1);
            end else if (issue_live) begin
                r_ptr <= r_ptr + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_latch) begin
            r_req_tag  <= i_req.task_tag;
            r_req_prio <= i_req.priority_req;
        end
        if (best_upd) begin
            r_best_idx  <= r_rd_idx;
            r_best_tag  <= r_rd_tag;
            r_best_prio <= r_rd_prio;
        end
        if (i_cmd.res_load) begin
            r_resp.out_tag      <= i_cmd.res_entry ? r_best_tag : 32'd0;
            r_resp.out_priority <= i_cmd.res_entry ? r_best_prio : 16'd0;
            r_resp.out_valid    <= i_cmd.res_entry;
            r_resp.status       <= i_cmd.res_status;
            r_resp.entry_count  <= count_ext[COUNT_W-1:0];
            r_resp.is_empty     <= (n_count == '0);
        end
    end

    assign o_stat.empty      = (r_count == '0);
    assign o_stat.full       = (r_count == CW'(QUEUE_DEPTH));
    assign o_stat.scan_done  = r_rd_live && (r_rd_idx == (r_count - CW'(1)));
    assign o_stat.shift_done = !r_rd_live && !(r_ptr < r_count);
    assign o_resp            = r_resp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_wr |-> (r_count < CW'(QUEUE_DEPTH)))
        else $error("push written into a full queue");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.shift_en && r_rd_live) |-> ((r_rd_idx != '0) && (r_rd_idx < r_count)))
        else $error("shift move outside stored entries");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.count_dec |-> (r_count != '0))
        else $error("pop from an empty queue");

endmodule

// ===== rtl/mpq_ctrl.sv =====
// controller of the max priority queue unit: request/response handshake
// and the scan, reposition and shift sequence of a pop or peek
// depends on mpq_pkg
module mpq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  logic [1:0]        i_req_cmd,
    output logic              o_resp_valid,
    input  logic              i_resp_ready,
    input  mpq_pkg::t_dp_stat i_stat,
    output mpq_pkg::t_dp_cmd  o_cmd
);
    import mpq_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_cmd;
    logic [1:0] n_cmd;
    logic [1:0] r_status;
    logic [1:0] n_status;
    logic       r_entry;
    logic       n_entry;
    logic       r_out_vld;
    logic       n_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_cmd     <= CMD_PUSH;
            r_status  <= ST_OK;
            r_entry   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_cmd     <= n_cmd;
            r_status  <= n_status;
            r_entry   <= n_entry;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_status    = r_status;
        n_entry     = r_entry;
        n_out_vld   = r_out_vld && !i_resp_ready;
        o_cmd       = '0;
        o_req_ready = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.req_latch = 1'b1;
                    n_cmd           = i_req_cmd;
                    n_status        = ST_OK;
                    n_entry         = 1'b0;
                    n_state         = S_RESP;
                    case (i_req_cmd)
                        CMD_PUSH: begin
                            if (i_stat.full) begin
                                n_status = ST_FULL;
                            end
                        end
                        CMD_POP, CMD_PEEK: begin
                            if (i_stat.empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                o_cmd.ptr_clr = 1'b1;
                                n_state       = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_stat.scan_done) begin
                    n_entry = 1'b1;
                    n_state = (r_cmd == CMD_POP) ? S_POS : S_RESP;
                end
            end
            S_POS: begin
                // start the shift just past the winning entry
                o_cmd.ptr_from_best = 1'b1;
                n_state             = S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.shift_en = 1'b1;
                if (i_stat.shift_done) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_out_vld || i_resp_ready) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_entry  = r_entry;
                    o_cmd.res_status = r_status;
                    o_cmd.push_wr    = (r_cmd == CMD_PUSH) && (r_status == ST_OK);
                    o_cmd.count_inc  = (r_cmd == CMD_PUSH) && (r_status == ST_OK);
                    o_cmd.count_dec  = (r_cmd == CMD_POP) && r_entry;
                    n_out_vld        = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_resp_valid = r_out_vld;

    a_one_wr_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.push_wr && o_cmd.shift_en))
        else $error("push and shift write in the same cycle");

    a_pop_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.count_dec |-> (o_cmd.res_entry && (o_cmd.res_status == ST_OK)))
        else $error("count decrement without a popped entry");

    a_shift_after_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_cmd.shift_en) |-> $past(o_cmd.ptr_from_best))
        else $error("shift started without repositioning the pointer");

endmodule

// ===== rtl/max_priority_queue_unit.sv =====
// Bounded max-priority queue of QUEUE_DEPTH (tag, priority) entries kept in
// insertion order. Requests: push appends, pop removes and returns the first
// entry of highest priority, peek returns it without removing. Each request
// gives one response with the count and empty flag after it. One request is
// worked at a time: peek and pop read the entries one by one, one memory read
// per entry, and pop then shifts the later entries down one per cycle. A
// finished response waits in an output register while the next request is
// accepted.
// depends on mpq_pkg, mpq_ctrl, mpq_dp
module max_priority_queue_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  mpq_pkg::t_req  i_req,
    output logic           o_resp_valid,
    input  logic           i_resp_ready,
    output mpq_pkg::t_resp o_resp
);
    import mpq_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    mpq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_req_cmd    (i_req.cmd),
        .o_resp_valid (o_resp_valid),
        .i_resp_ready (i_resp_ready),
        .i_stat       (dp_stat),
        .o_cmd        (dp_cmd)
    );

    mpq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat),
        .o_resp  (o_resp)
    );

endmodule

// ===== verif/mpq_checker.sv =====
// checker for the max priority queue unit: watches both channels, predicts
// each response from the accepted requests and compares field by field
// depends on mpq_pkg
`timescale 1ns / 1ps

module mpq_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_ready,
    input  mpq_pkg::t_req  i_req,
    input  logic           i_resp_valid,
    input  logic           i_resp_ready,
    input  mpq_pkg::t_resp i_resp,
    output int             o_fail_count,
    output int             o_pending
);
    import mpq_pkg::*;

    logic [31:0] shadow_tags [QUEUE_DEPTH];
    logic [15:0] shadow_prios [QUEUE_DEPTH];
    int          shadow_count;
    t_resp       resp_expected_q [$];
    int          fail_count;

    assign o_fail_count = fail_count;

    initial begin
        fail_count   = 0;
        shadow_count = 0;
    end

    task automatic report_error(input string msg);
        $display("mpq_checker: %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("%s got 0x%0h, want 0x%0h", field, got, want));
    endtask

    // applies one request to the shadow queue and gives the response it causes
    function automatic t_resp queue_apply(input t_req r);
        t_resp rsp;
        int    top;
        rsp = '0;
        rsp.status = ST_OK;
        case (r.cmd)
            CMD_PUSH: begin
                if (shadow_count >= QUEUE_DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    shadow_tags[shadow_count]  = r.task_tag;
                    shadow_prios[shadow_count] = r.priority_req;
                    shadow_count++;
                end
            end
            CMD_POP, CMD_PEEK: begin
                if (shadow_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    // strict compare: earliest entry wins ties
                    top = 0;
                    for (int i = 1; i < shadow_count; i++)
                        if (shadow_prios[i] > shadow_prios[top])
                            top = i;
                    rsp.out_tag      = shadow_tags[top];
                    rsp.out_priority = shadow_prios[top];
                    rsp.out_valid    = 1'b1;
                    if (r.cmd == CMD_POP) begin
                        for (int i = top; i + 1 < shadow_count; i++) begin
                            shadow_tags[i]  = shadow_tags[i + 1];
                            shadow_prios[i] = shadow_prios[i + 1];
                        end
                        shadow_count--;
                    end
                end
            end
            default: ;
        endcase
        rsp.entry_count = COUNT_W'(shadow_count);
        rsp.is_empty    = (shadow_count == 0);
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_resp want;
        if (i_rst_n) begin
            if (i_resp_valid && i_resp_ready) begin
                if (resp_expected_q.size() == 0) begin
                    report_error("response with no request outstanding");
                end else begin
                    want = resp_expected_q.pop_front();
                    check_field("out_tag", i_resp.out_tag, want.out_tag);
                    check_field("out_priority", 32'(i_resp.out_priority),
                                32'(want.out_priority));
                    check_field("out_valid", 32'(i_resp.out_valid), 32'(want.out_valid));
                    check_field("status", 32'(i_resp.status), 32'(want.status));
                    check_field("entry_count", 32'(i_resp.entry_count),
                                32'(want.entry_count));
                    check_field("is_empty", 32'(i_resp.is_empty), 32'(want.is_empty));
                end
            end
            if (i_req_valid && i_req_ready)
                resp_expected_q.push_back(queue_apply(i_req));
        end
        o_pending <= resp_expected_q.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// top of the max priority queue testbench: clock, reset, request stimulus,
// response back-pressure and the verdict
// depends on mpq_pkg, max_priority_queue_unit and mpq_checker
`timescale 1ns / 1ps

module tb_top;
    import mpq_pkg::*;

    localparam int QUEUE_DEPTH   = 16;
    localparam int ITEMS_PER_MIX = 32;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    logic  i_clk;
    logic  i_rst_n = 1'b0;
    logic  i_req_valid = 1'b0;
    logic  o_req_ready;
    t_req  i_req = '0;
    logic  o_resp_valid;
    logic  i_resp_ready = 1'b0;
    t_resp o_resp;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;

    max_priority_queue_unit #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_resp_valid(o_resp_valid),
        .i_resp_ready(i_resp_ready),
        .o_resp      (o_resp)
    );

    mpq_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req_ready (o_req_ready),
        .i_req       (i_req),
        .i_resp_valid(o_resp_valid),
        .i_resp_ready(i_resp_ready),
        .i_resp      (o_resp),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_resp_ready <= 1'b0;
        else
            i_resp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // valid stays high across back-to-back requests; it drops only for a gap
    task automatic send_req(input logic [1:0] cmd, input logic [31:0] tag,
                            input logic [15:0] prio);
        t_req r;
        r.cmd          = cmd;
        r.task_tag     = tag;
        r.priority_req = prio;
        while ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (!o_req_ready);
    endtask

    // partly a narrow range so ties are common, with the extremes mixed in, else full-range values
    function automatic logic [15:0] pick_prio();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0:       return 16'h0000;
            1:       return 16'hffff;
            2, 3, 4: return 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_tag();
        int sel;
        sel = $urandom_range(19);
        if (sel == 0)
            return 32'h0;
        else if (sel == 1)
            return 32'hffff_ffff;
        return $urandom;
    endfunction

    function automatic logic [1:0] pick_cmd(input t_mix mix);
        int roll;
        int push_pct;
        int pop_pct;
        roll = $urandom_range(99);
        case (mix)
            MIX_FILL: begin
                push_pct = 70;
                pop_pct  = 15;
            end
            MIX_DRAIN: begin
                push_pct = 20;
                pop_pct  = 65;
            end
            default: begin
                push_pct = 45;
                pop_pct  = 30;
            end
        endcase
        if (roll < push_pct)
            return CMD_PUSH;
        else if (roll < push_pct + pop_pct)
            return CMD_POP;
        else if (roll < 96)
            return CMD_PEEK;
        return CMD_NOP;
    endfunction

    task automatic run_random(input int n_items);
        t_mix mix;
        mix = MIX_EVEN;
        for (int i = 0; i < n_items; i++) begin
            if (i % ITEMS_PER_MIX == 0)
                mix = t_mix'($urandom_range(2));
            send_req(pick_cmd(mix), pick_tag(), pick_prio());
        end
    endtask

    initial begin
        int guard;
        send_idle_pct = 31;
        recv_idle_pct = 69;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue: pop, peek and the unused command
        send_req(CMD_POP, 32'hdead_beef, 16'h1234);
        send_req(CMD_PEEK, 32'h0, 16'h0);
        send_req(CMD_NOP, 32'hffff_ffff, 16'hffff);
        // extremes of tag and priority, plus a tie at the top
        send_req(CMD_PUSH, 32'h0000_0000, 16'h0000);
        send_req(CMD_PUSH, 32'hffff_ffff, 16'hffff);
        send_req(CMD_PUSH, 32'h5555_aaaa, 16'hffff);
        send_req(CMD_PUSH, 32'haaaa_5555, 16'h8000);
        send_req(CMD_NOP, 32'h1, 16'h1);
        send_req(CMD_PEEK, 32'h0, 16'h0);
        send_req(CMD_POP, 32'h0, 16'h0);
        send_req(CMD_POP, 32'h0, 16'h0);
        send_req(CMD_POP, 32'h0, 16'h0);
        send_req(CMD_PEEK, 32'h0, 16'h0);
        send_req(CMD_POP, 32'h0, 16'h0);
        send_req(CMD_POP, 32'h0, 16'h0);

        run_random(400);
        send_idle_pct = 69;
        recv_idle_pct = 31;
        run_random(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(400);
        i_req_valid <= 1'b0;

        guard = 0;
        while (pending != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        #6ms;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mpq_pkg.sv
rtl/mpq_dp.sv
rtl/mpq_ctrl.sv
rtl/max_priority_queue_unit.sv
verif/mpq_checker.sv
verif/tb_top.sv
